/* rtl/udpd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// udpd_pkg
// Shared types and constants of the UDP receive port demultiplexer.
// ----------------------------------------------------------------------------
package udpd_pkg;

    localparam int TABLE_SLOTS = 8;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int HDR_LEN     = 8;
    localparam int HDR_STORE   = 6;

    typedef enum logic [1:0] {
        OP_BIND   = 2'd0,
        OP_UNBIND = 2'd1,
        OP_BYTE   = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        KIND_BIND_OK = 3'd0,
        KIND_FULL    = 3'd1,
        KIND_UNBIND  = 3'd2,
        KIND_BYTE    = 3'd3,
        KIND_EMPTY   = 3'd4
    } t_kind;

    typedef struct packed {
        t_opcode     opcode;
        logic [15:0] port;
        logic [7:0]  client_tag;
        logic [7:0]  rx_byte;
        logic [15:0] frame_length;
        logic [31:0] source_address;
    } t_request;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  dest_tag;
        logic [15:0] source_port;
        logic [31:0] origin_address;
        logic [7:0]  payload_byte;
        logic [15:0] payload_size;
        logic        last;
    } t_result;

endpackage
`default_nettype wire

/* rtl/udpd_ifs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// udpd_ifs
// Request and result channels of the UDP receive port demultiplexer.
// ----------------------------------------------------------------------------
interface udpd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] port;
    logic [7:0]  client_tag;
    logic [7:0]  rx_byte;
    logic [15:0] frame_length;
    logic [31:0] source_address;

    modport source (output valid, output opcode, output port, output client_tag,
                    output rx_byte, output frame_length, output source_address,
                    input ready);
    modport sink   (input valid, input opcode, input port, input client_tag,
                    input rx_byte, input frame_length, input source_address,
                    output ready);
endinterface

interface udpd_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  dest_tag;
    logic [15:0] source_port;
    logic [31:0] origin_address;
    logic [7:0]  payload_byte;
    logic [15:0] payload_size;
    logic        last;

    modport source (output valid, output kind, output dest_tag, output source_port,
                    output origin_address, output payload_byte, output payload_size,
                    output last, input ready);
    modport sink   (input valid, input kind, input dest_tag, input source_port,
                    input origin_address, input payload_byte, input payload_size,
                    input last, output ready);
endinterface
`default_nettype wire

/* rtl/udpd_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// udpd_front
// Listener table, header parser and frame validation; while the result queue is not full, one request per cycle.
// ----------------------------------------------------------------------------
module udpd_front
    import udpd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_req_valid,
    input  wire t_request i_req,
    output logic          o_req_ready,
    input  wire logic     i_full,
    output logic          o_push,
    output t_result       o_result
);

    logic [15:0]       r_slot_port  [TABLE_SLOTS];
    logic [7:0]        r_slot_tag   [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] r_slot_bound;
    logic [15:0]       r_byte_count;
    logic [47:0]       r_header;
    logic [SLOT_W-1:0] r_match_slot;
    logic              r_accepted;

    logic [15:0]       n_slot_port  [TABLE_SLOTS];
    logic [7:0]        n_slot_tag   [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] n_slot_bound;
    logic [15:0]       n_byte_count;
    logic [47:0]       n_header;
    logic [SLOT_W-1:0] n_match_slot;
    logic              n_accepted;

    logic                   w_accept;
    logic [TABLE_SLOTS-1:0] w_hit_bind;
    logic [TABLE_SLOTS-1:0] w_hit_dst;
    logic [SLOT_W-1:0]      w_bind_idx;
    logic [SLOT_W-1:0]      w_dst_idx;
    logic [15:0]            w_dport;
    logic [15:0]            w_decl;
    logic [16:0]            w_pos_inc;
    logic                   w_len_ok;

    assign o_req_ready = !i_full;
    assign w_accept    = i_req_valid && !i_full;
    assign w_dport     = r_header[31:16];
    assign w_decl      = r_header[15:0];
    assign w_pos_inc   = {1'b0, r_byte_count} + 17'd1;
    assign w_len_ok    = (w_decl >= 16'(HDR_LEN)) && (w_decl <= i_req.frame_length);

    always_comb begin
        w_bind_idx = '0;
        w_dst_idx  = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
            w_hit_bind[i] = (r_slot_port[i] == 16'd0) || (r_slot_port[i] == i_req.port);
            w_hit_dst[i]  = r_slot_bound[i] && (r_slot_port[i] == w_dport);
            if (w_hit_bind[i]) begin
                w_bind_idx = SLOT_W'(i);
            end
            if (w_hit_dst[i]) begin
                w_dst_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_slot_port  = r_slot_port;
        n_slot_tag   = r_slot_tag;
        n_slot_bound = r_slot_bound;
        n_byte_count = r_byte_count;
        n_header     = r_header;
        n_match_slot = r_match_slot;
        n_accepted   = r_accepted;
        o_push       = 1'b0;
        o_result     = '0;
        if (w_accept) begin
            case (i_req.opcode)
                OP_BIND: begin
                    o_push = 1'b1;
                    if (|w_hit_bind) begin
                        n_slot_port[w_bind_idx]  = i_req.port;
                        n_slot_tag[w_bind_idx]   = i_req.client_tag;
                        n_slot_bound[w_bind_idx] = 1'b1;
                        o_result.kind = KIND_BIND_OK;
                    end else begin
                        o_result.kind = KIND_FULL;
                    end
                end
                OP_UNBIND: begin
                    o_push        = 1'b1;
                    o_result.kind = KIND_UNBIND;
                    for (int i = 0; i < TABLE_SLOTS; i++) begin
                        if (r_slot_port[i] == i_req.port) begin
                            n_slot_port[i]  = 16'd0;
                            n_slot_tag[i]   = 8'd0;
                            n_slot_bound[i] = 1'b0;
                        end
                    end
                end
                OP_BYTE: begin
                    o_result.source_port    = r_header[47:32];
                    o_result.origin_address = i_req.source_address;
                    o_result.payload_size   = w_decl - 16'(HDR_LEN);
                    if (r_byte_count < 16'(HDR_STORE)) begin
                        n_header = {r_header[39:0], i_req.rx_byte};
                        if (r_byte_count == 16'd0) begin
                            n_accepted = 1'b0;
                        end
                    end else if (r_byte_count == 16'(HDR_LEN - 1)) begin
                        n_accepted = 1'b0;
                        if (w_len_ok && |w_hit_dst) begin
                            n_match_slot = w_dst_idx;
                            if (w_decl == 16'(HDR_LEN)) begin
                                o_push            = 1'b1;
                                o_result.kind     = KIND_EMPTY;
                                o_result.dest_tag = r_slot_tag[w_dst_idx];
                                o_result.last     = 1'b1;
                            end else begin
                                n_accepted = 1'b1;
                            end
                        end
                    end else if (r_byte_count >= 16'(HDR_LEN) && r_accepted
                                 && r_byte_count < w_decl) begin
                        o_push                = 1'b1;
                        o_result.kind         = KIND_BYTE;
                        o_result.dest_tag     = r_slot_tag[r_match_slot];
                        o_result.payload_byte = i_req.rx_byte;
                        o_result.last         = (w_pos_inc == {1'b0, w_decl});
                    end
                    if (w_pos_inc >= {1'b0, i_req.frame_length}) begin
                        n_byte_count = 16'd0;
                        n_accepted   = 1'b0;
                    end else begin
                        n_byte_count = w_pos_inc[15:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                r_slot_port[i] <= 16'd0;
                r_slot_tag[i]  <= 8'd0;
            end
            r_slot_bound <= '0;
            r_byte_count <= 16'd0;
            r_header     <= 48'd0;
            r_match_slot <= '0;
            r_accepted   <= 1'b0;
        end else begin
            r_slot_port  <= n_slot_port;
            r_slot_tag   <= n_slot_tag;
            r_slot_bound <= n_slot_bound;
            r_byte_count <= n_byte_count;
            r_header     <= n_header;
            r_match_slot <= n_match_slot;
            r_accepted   <= n_accepted;
        end
    end

endmodule
`default_nettype wire

/* rtl/udpd_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// udpd_fifo
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module udpd_fifo
    import udpd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_full,
    input  wire logic    i_pop,
    output t_result      o_data,
    output logic         o_empty
);

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_AW:0]     r_count;
    logic                 w_do_push;
    logic                 w_do_pop;

    assign o_full    = (r_count == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/udpd_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// udpd_back
// Output register: drains the result queue onto the result channel.
// ----------------------------------------------------------------------------
module udpd_back
    import udpd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_result i_data,
    input  wire logic    i_empty,
    output logic         o_pop,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_data
);

    logic    r_valid;
    t_result r_data;

    assign o_pop   = !i_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_data;
        end
    end

endmodule
`default_nettype wire

/* rtl/udp_port_demux.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// udp_port_demux
// Receive-side UDP port demultiplexer with a table of listener slots.
//
// i_req carries one request per handshake: bind a port to a client tag,
// unbind a port, or one datagram byte with its frame length and source
// address. o_res carries bind/unbind answers and payload bytes tagged with
// the client of the matching listener; an accepted empty datagram gives one
// empty-payload result. Malformed or unmatched frames and trailing bytes
// give no result. Throughput: one request per cycle while the result queue
// is not full; the parser handles each request in the cycle it is accepted
// and the output register drains one result per cycle while o_res is ready.
// A result reaches o_res through the queue and then the output register.
// When o_res stalls, results collect in the four-entry queue; i_req.ready
// falls once the queue is full and rises when the output register frees it.
// Reset clears the listener table, the frame position and the queue.
// ----------------------------------------------------------------------------
module udp_port_demux
    import udpd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    udpd_req_if.sink   i_req,
    udpd_res_if.source o_res
);

    t_request w_req;
    t_result  w_push_data;
    t_result  w_pop_data;
    t_result  w_out;
    logic     w_push;
    logic     w_full;
    logic     w_pop;
    logic     w_empty;
    logic     w_ready;
    logic     w_out_valid;

    always_comb begin
        w_req.opcode         = t_opcode'(i_req.opcode);
        w_req.port           = i_req.port;
        w_req.client_tag     = i_req.client_tag;
        w_req.rx_byte        = i_req.rx_byte;
        w_req.frame_length   = i_req.frame_length;
        w_req.source_address = i_req.source_address;
    end

    udpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req       (w_req),
        .o_req_ready (w_ready),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_result    (w_push_data)
    );

    udpd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_empty (w_empty)
    );

    udpd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (w_pop_data),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (w_out_valid),
        .i_ready (o_res.ready),
        .o_data  (w_out)
    );

    assign i_req.ready          = w_ready;
    assign o_res.valid          = w_out_valid;
    assign o_res.kind           = w_out.kind;
    assign o_res.dest_tag       = w_out.dest_tag;
    assign o_res.source_port    = w_out.source_port;
    assign o_res.origin_address = w_out.origin_address;
    assign o_res.payload_byte   = w_out.payload_byte;
    assign o_res.payload_size   = w_out.payload_size;
    assign o_res.last           = w_out.last;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("result queue written while full");

    a_empty_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind == KIND_EMPTY) |->
            (o_res.last && o_res.payload_size == 16'd0))
        else $error("empty payload result malformed");

    a_byte_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind == KIND_BYTE) |-> (o_res.payload_size != 16'd0))
        else $error("payload byte with zero payload size");

    a_table_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.kind == KIND_BIND_OK || o_res.kind == KIND_FULL
                         || o_res.kind == KIND_UNBIND)) |->
            (o_res.dest_tag == 8'd0 && !o_res.last && o_res.payload_size == 16'd0))
        else $error("table reply carries datagram fields");

endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UDP receive port demultiplexer.
//
// A queue of requests (binds, unbinds, datagram bytes, unused opcodes) is
// built up front: a short directed opening, then mostly well-formed
// datagrams with random content, mixed with malformed frames and listener
// table changes, some of them in the middle of a frame. A driver feeds the
// queue into i_req with random gaps. A monitor predicts the results of each
// accepted request from its own copy of the listener table and frame parser
// and compares every result taken from o_res, field by field, with the
// oldest prediction. The receiver stalls at random and twice holds off long
// enough for the block to fill up and stall its input.
// ----------------------------------------------------------------------------
module testbench;
    import udpd_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int TARGET_ITEMS = 650;
    localparam int POOL_N       = 12;
    localparam int HOLD_CYCLES  = 300;

    logic i_clk;
    logic i_rst_n;

    udpd_req_if req_ch ();
    udpd_res_if res_ch ();

    udp_port_demux u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    // stimulus and expectations
    t_request    request_queue[$];
    t_result     awaited_results[$];
    logic [15:0] port_pool[POOL_N];
    int          stim_items;
    int          errors;
    int          cycles;
    int          requests_taken;

    // listener table and frame parser copy
    logic [15:0] lst_port[TABLE_SLOTS];
    logic [7:0]  lst_tag[TABLE_SLOTS];
    logic        lst_bound[TABLE_SLOTS];
    logic [15:0] rx_pos;
    logic [47:0] hdr_shift;
    int          hit_slot;
    logic        frame_open;

    // handshake bookkeeping
    logic     req_taken;
    logic     res_taken;
    logic     in_flight;
    t_request cur_req;
    int       req_wait;
    bit       req_quiet;
    int       res_wait;
    bit       res_quiet;
    int       hold_left;
    int       holds_done;

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int pick_wait(inout bit quiet);
        if ($urandom_range(0, 24) == 0) quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    task automatic route_request(input t_request rq);
        t_result     r;
        int          i;
        int          pos;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] decl;
        bit          hit;
        r   = '0;
        hit = 1'b0;
        case (rq.opcode)
            OP_BIND: begin
                r.kind = KIND_FULL;
                for (i = 0; i < TABLE_SLOTS; i++) begin
                    if (!hit && (lst_port[i] == 16'd0 || lst_port[i] == rq.port)) begin
                        lst_port[i]  = rq.port;
                        lst_tag[i]   = rq.client_tag;
                        lst_bound[i] = 1'b1;
                        r.kind       = KIND_BIND_OK;
                        hit          = 1'b1;
                    end
                end
                awaited_results.push_back(r);
            end
            OP_UNBIND: begin
                for (i = 0; i < TABLE_SLOTS; i++) begin
                    if (lst_port[i] == rq.port) begin
                        lst_port[i]  = 16'd0;
                        lst_tag[i]   = 8'd0;
                        lst_bound[i] = 1'b0;
                    end
                end
                r.kind = KIND_UNBIND;
                awaited_results.push_back(r);
            end
            OP_BYTE: begin
                pos   = int'(rx_pos);
                sport = hdr_shift[47:32];
                if (pos < 6) begin
                    hdr_shift = {hdr_shift[39:0], rq.rx_byte};
                    if (pos == 0) frame_open = 1'b0;
                end else if (pos == 7) begin
                    dport      = hdr_shift[31:16];
                    decl       = hdr_shift[15:0];
                    frame_open = 1'b0;
                    if (decl >= 16'd8 && decl <= rq.frame_length) begin
                        for (i = 0; i < TABLE_SLOTS; i++) begin
                            if (!frame_open && lst_bound[i] && lst_port[i] == dport) begin
                                hit_slot   = i;
                                frame_open = 1'b1;
                            end
                        end
                    end
                    if (frame_open && decl == 16'd8) begin
                        r.kind           = KIND_EMPTY;
                        r.dest_tag       = lst_tag[hit_slot];
                        r.source_port    = sport;
                        r.origin_address = rq.source_address;
                        r.last           = 1'b1;
                        awaited_results.push_back(r);
                        frame_open = 1'b0;
                    end
                end else if (pos >= 8 && frame_open) begin
                    decl = hdr_shift[15:0];
                    if (pos < int'(decl)) begin
                        r.kind           = KIND_BYTE;
                        r.dest_tag       = lst_tag[hit_slot];
                        r.source_port    = sport;
                        r.origin_address = rq.source_address;
                        r.payload_byte   = rq.rx_byte;
                        r.payload_size   = decl - 16'd8;
                        r.last           = (pos + 1 == int'(decl));
                        awaited_results.push_back(r);
                    end
                end
                if (pos + 1 >= int'(rq.frame_length)) begin
                    rx_pos     = 16'd0;
                    frame_open = 1'b0;
                end else begin
                    rx_pos = 16'(pos + 1);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 100)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
        end
    endtask

    task automatic push_req(input t_opcode op, input logic [15:0] port,
                            input logic [7:0] tag, input logic [7:0] data,
                            input logic [15:0] flen, input logic [31:0] src);
        t_request rq;
        rq.opcode         = op;
        rq.port           = port;
        rq.client_tag     = tag;
        rq.rx_byte        = data;
        rq.frame_length   = flen;
        rq.source_address = src;
        request_queue.push_back(rq);
        stim_items++;
    endtask

    task automatic queue_table_op(input bit unbind);
        logic [15:0] p;
        p = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                        : port_pool[$urandom_range(0, POOL_N - 1)];
        push_req(unbind ? OP_UNBIND : OP_BIND, p, 8'($urandom), 8'($urandom),
                 16'($urandom), $urandom);
    endtask

    task automatic queue_noise();
        push_req(OP_NONE, 16'($urandom), 8'($urandom), 8'($urandom),
                 16'($urandom), $urandom);
    endtask

    task automatic queue_datagram();
        int          sel;
        int          total;
        int          plen;
        int          tail;
        int          decl;
        int          k;
        bit          mid_ops;
        logic [15:0] flen_body;
        logic [15:0] fl;
        logic [15:0] dport;
        logic [15:0] sport;
        logic [15:0] cks;
        logic [15:0] d16;
        logic [31:0] src;
        logic [63:0] hdr_bits;
        logic [7:0]  b;
        sel     = $urandom_range(0, 99);
        mid_ops = 1'b0;
        dport   = ($urandom_range(0, 6) == 0) ? 16'($urandom)
                                              : port_pool[$urandom_range(0, POOL_N - 1)];
        sport   = 16'($urandom);
        cks     = 16'($urandom);
        src     = $urandom;
        if (sel < 66) begin
            // well formed, sometimes with trailing bytes
            plen      = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                    : $urandom_range(0, 12);
            decl      = 8 + plen;
            tail      = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            total     = decl + tail;
            flen_body = 16'(total);
            mid_ops   = 1'b1;
        end else if (sel < 73) begin
            // short frame
            total     = $urandom_range(1, 7);
            decl      = $urandom_range(0, 65535);
            flen_body = 16'(total);
        end else if (sel < 78) begin
            // declared length below header size
            decl      = $urandom_range(0, 7);
            total     = $urandom_range(8, 14);
            flen_body = 16'(total);
        end else if (sel < 85) begin
            // declared length beyond frame
            total     = $urandom_range(8, 20);
            decl      = $urandom_range(total + 1, 65535);
            flen_body = 16'(total);
        end else if (sel < 90) begin
            // one-byte frame, length zero
            total     = 1;
            decl      = 0;
            flen_body = 16'd0;
        end else begin
            // large frame length, frame cut short by the last byte
            decl      = $urandom_range(8, 65535);
            total     = $urandom_range(9, 24);
            flen_body = 16'($urandom_range((decl > 32) ? decl : 32, 65535));
        end
        d16      = 16'(decl);
        hdr_bits = {sport, dport, d16, cks};
        for (k = 0; k < total; k++) begin
            b  = (k < 8) ? hdr_bits[63 - 8 * k -: 8] : 8'($urandom);
            fl = (sel >= 90 && k == total - 1) ? 16'(total) : flen_body;
            push_req(OP_BYTE, 16'($urandom), 8'($urandom), b, fl, src);
            if (mid_ops && k != total - 1) begin
                if ($urandom_range(0, 29) == 0) queue_table_op(1'($urandom_range(0, 1)));
                else if ($urandom_range(0, 49) == 0) queue_noise();
            end
        end
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (req_taken) in_flight = 1'b0;
            if (!in_flight) begin
                if (req_wait > 0) begin
                    req_wait--;
                end else if (request_queue.size() != 0) begin
                    cur_req   = request_queue.pop_front();
                    in_flight = 1'b1;
                    req_wait  = pick_wait(req_quiet);
                    req_ch.opcode         <= cur_req.opcode;
                    req_ch.port           <= cur_req.port;
                    req_ch.client_tag     <= cur_req.client_tag;
                    req_ch.rx_byte        <= cur_req.rx_byte;
                    req_ch.frame_length   <= cur_req.frame_length;
                    req_ch.source_address <= cur_req.source_address;
                end
            end
            req_ch.valid <= in_flight;
        end
    end

    // receiver
    always @(negedge i_clk) begin
        logic rdy;
        if (res_taken) res_wait = pick_wait(res_quiet);
        if (holds_done < 2 && requests_taken >= 200 + 250 * holds_done) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (res_wait > 0) begin
            res_wait--;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
        end
        res_ch.ready <= rdy;
    end

    // monitor
    always @(posedge i_clk) begin
        t_request rq;
        t_result  got;
        t_result  want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            req_taken <= i_rst_n && req_ch.valid && req_ch.ready;
            res_taken <= i_rst_n && res_ch.valid && res_ch.ready;
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                got.kind           = t_kind'(res_ch.kind);
                got.dest_tag       = res_ch.dest_tag;
                got.source_port    = res_ch.source_port;
                got.origin_address = res_ch.origin_address;
                got.payload_byte   = res_ch.payload_byte;
                got.payload_size   = res_ch.payload_size;
                got.last           = res_ch.last;
                if (awaited_results.size() == 0) begin
                    errors++;
                    if (errors <= 100)
                        $display("%0t: unexpected result, expected none, actual %0h",
                                 $time, got);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(got.kind));
                    check_field("dest_tag", 32'(want.dest_tag), 32'(got.dest_tag));
                    check_field("source_port", 32'(want.source_port),
                                32'(got.source_port));
                    check_field("origin_address", want.origin_address,
                                got.origin_address);
                    check_field("payload_byte", 32'(want.payload_byte),
                                32'(got.payload_byte));
                    check_field("payload_size", 32'(want.payload_size),
                                32'(got.payload_size));
                    check_field("last", 32'(want.last), 32'(got.last));
                end
            end
            if (i_rst_n && req_ch.valid && req_ch.ready) begin
                rq.opcode         = t_opcode'(req_ch.opcode);
                rq.port           = req_ch.port;
                rq.client_tag     = req_ch.client_tag;
                rq.rx_byte        = req_ch.rx_byte;
                rq.frame_length   = req_ch.frame_length;
                rq.source_address = req_ch.source_address;
                route_request(rq);
                requests_taken++;
            end
        end
    end

    initial begin
        int i;
        int sel;
        i_clk                 = 1'b0;
        i_rst_n               = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.opcode         = OP_NONE;
        req_ch.port           = '0;
        req_ch.client_tag     = '0;
        req_ch.rx_byte        = '0;
        req_ch.frame_length   = '0;
        req_ch.source_address = '0;
        res_ch.ready          = 1'b0;
        req_taken      = 1'b0;
        res_taken      = 1'b0;
        in_flight      = 1'b0;
        req_wait       = 0;
        req_quiet      = 1'b0;
        res_wait       = 0;
        res_quiet      = 1'b0;
        hold_left      = 0;
        holds_done     = 0;
        stim_items     = 0;
        errors         = 0;
        cycles         = 0;
        requests_taken = 0;
        for (i = 0; i < TABLE_SLOTS; i++) begin
            lst_port[i]  = 16'd0;
            lst_tag[i]   = 8'd0;
            lst_bound[i] = 1'b0;
        end
        rx_pos     = 16'd0;
        hdr_shift  = 48'd0;
        hit_slot   = 0;
        frame_open = 1'b0;

        port_pool[0] = 16'h0000;
        port_pool[1] = 16'hFFFF;
        for (i = 2; i < POOL_N; i++) port_pool[i] = 16'($urandom);

        // directed: binds incl. rebind and port zero, stray unbind, unused opcode
        push_req(OP_BIND, 16'h1234, 8'hA5, 8'h00, 16'h0000, 32'h0);
        push_req(OP_BIND, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        push_req(OP_BIND, 16'h1234, 8'h5A, 8'h00, 16'h0000, 32'h0);
        push_req(OP_BIND, 16'h0000, 8'h00, 8'h00, 16'h0000, 32'h0);
        push_req(OP_UNBIND, 16'h4321, 8'h00, 8'h00, 16'h0000, 32'h0);
        push_req(OP_NONE, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        // length zero frame: single byte dropped
        push_req(OP_BYTE, 16'h0, 8'h0, 8'hFF, 16'h0000, 32'hFFFF_FFFF);
        // empty payload to 0xFFFF
        push_req(OP_BYTE, 16'h0, 8'h0, 8'hFF, 16'd8, 32'hFFFF_FFFF);
        push_req(OP_BYTE, 16'h0, 8'h0, 8'hFF, 16'd8, 32'hFFFF_FFFF);
        push_req(OP_BYTE, 16'h0, 8'h0, 8'hFF, 16'd8, 32'hFFFF_FFFF);
        push_req(OP_BYTE, 16'h0, 8'h0, 8'hFF, 16'd8, 32'hFFFF_FFFF);
        push_req(OP_BYTE, 16'h0, 8'h0, 8'h00, 16'd8, 32'hFFFF_FFFF);
        push_req(OP_BYTE, 16'h0, 8'h0, 8'h08, 16'd8, 32'hFFFF_FFFF);
        push_req(OP_BYTE, 16'h0, 8'h0, 8'hFF, 16'd8, 32'hFFFF_FFFF);
        push_req(OP_BYTE, 16'h0, 8'h0, 8'hFF, 16'd8, 32'hFFFF_FFFF);
        // one payload byte to port zero
        push_req(OP_BYTE, 16'h0, 8'h0, 8'h00, 16'd9, 32'h0);
        push_req(OP_BYTE, 16'h0, 8'h0, 8'h00, 16'd9, 32'h0);
        push_req(OP_BYTE, 16'h0, 8'h0, 8'h00, 16'd9, 32'h0);
        push_req(OP_BYTE, 16'h0, 8'h0, 8'h00, 16'd9, 32'h0);
        push_req(OP_BYTE, 16'h0, 8'h0, 8'h00, 16'd9, 32'h0);
        push_req(OP_BYTE, 16'h0, 8'h0, 8'h09, 16'd9, 32'h0);
        push_req(OP_BYTE, 16'h0, 8'h0, 8'h00, 16'd9, 32'h0);
        push_req(OP_BYTE, 16'h0, 8'h0, 8'h00, 16'd9, 32'h0);
        push_req(OP_BYTE, 16'h0, 8'h0, 8'h00, 16'd9, 32'h0);

        while (stim_items < TARGET_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 28) queue_table_op(1'b0);
            else if (sel < 36) queue_table_op(1'b1);
            else if (sel < 40) queue_noise();
            else queue_datagram();
        end

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_queue.size() != 0 || in_flight) @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
rtl/udpd_pkg.sv
rtl/udpd_ifs.sv
rtl/udpd_front.sv
rtl/udpd_fifo.sv
rtl/udpd_back.sv
rtl/udp_port_demux.sv
tb/testbench.sv
